// ===== rtl/gfq_pkg.sv =====
// Shared types and codes of the grouped FIFO queue.
package gfq_pkg;

  localparam int FIELD_W = 10;

  typedef enum logic [1:0] {
    OP_ASSIGN  = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_DEQUEUE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_VALID    = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Classified command word passed from the front queue to the engine
  typedef struct packed {
    op_t                  op;
    logic [FIELD_W-1:0]   elem;
    logic [FIELD_W-1:0]   grp;
    logic                 elem_ok;
    logic                 grp_ok;
  } cmd_t;

endpackage

// ===== rtl/gfq_front.sv =====
// Front end: accepts command words, range-checks them and buffers two.
module gfq_front #(
  parameter int GROUPS   = 1024,
  parameter int ELEMENTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_operation,
  input  logic [gfq_pkg::FIELD_W-1:0] in_element,
  input  logic [gfq_pkg::FIELD_W-1:0] in_group,
  output logic                  cmd_valid,
  input  logic                  cmd_pop,
  output gfq_pkg::cmd_t         cmd
);
  import gfq_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       new_cmd;
  logic       push;

  // Classify the incoming word
  always_comb begin
    new_cmd.op      = op_t'(in_operation);
    new_cmd.elem    = in_element;
    new_cmd.grp     = in_group;
    new_cmd.elem_ok = 32'(in_element) < ELEMENTS;
    new_cmd.grp_ok  = 32'(in_group) < GROUPS;
  end

  assign in_ready  = cnt_r != 2'd2;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready;

  // Hold the buffered words
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= new_cmd;
    end
  end

  // Advance the pointers and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ===== rtl/gfq_back.sv =====
// Back end: pointer memories, free list, group order ring and result register.
module gfq_back #(
  parameter int GROUPS   = 1024,
  parameter int CAPACITY = 1024,
  parameter int ELEMENTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_pop,
  input  gfq_pkg::cmd_t         cmd,
  output logic                  clearing,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [gfq_pkg::FIELD_W-1:0] out_element,
  output logic [1:0]            out_status
);
  import gfq_pkg::*;

  localparam int GW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EW   = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int MAXD = (GROUPS > CAPACITY) ?
                        ((GROUPS > ELEMENTS) ? GROUPS : ELEMENTS) :
                        ((CAPACITY > ELEMENTS) ? CAPACITY : ELEMENTS);
  localparam int MW   = $clog2(MAXD);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_E1, S_E2, S_E3, S_D1, S_D2, S_D3, S_DONE
  } state_t;

  // Memories
  logic [GW-1:0]      eg_mem  [ELEMENTS];
  logic [CW-1:0]      gh_mem  [GROUPS];
  logic [CW-1:0]      gt_mem  [GROUPS];
  logic               gne_mem [GROUPS];
  logic [FIELD_W-1:0] ev_mem  [CAPACITY];
  logic [CW-1:0]      en_mem  [CAPACITY];
  logic [GW-1:0]      oq_mem  [GROUPS];

  logic               eg_we, gh_we, gt_we, gne_we, ev_we, en_we, oq_we;
  logic [EW-1:0]      eg_wa, eg_ra;
  logic [GW-1:0]      eg_wd, eg_q;
  logic [GW-1:0]      gh_wa, gh_ra, gt_wa, gt_ra, gne_wa, gne_ra;
  logic [CW-1:0]      gh_wd, gh_q, gt_wd, gt_q;
  logic               gne_wd, gne_q;
  logic [CW-1:0]      ev_wa, ev_ra, en_wa, en_ra;
  logic [FIELD_W-1:0] ev_wd, ev_q;
  logic [CW-1:0]      en_wd, en_q;
  logic [GW-1:0]      oq_wa, oq_ra, oq_wd, oq_q;

  // Registers
  state_t             state_r, state_nxt;
  logic [MW-1:0]      clr_r, clr_nxt;
  logic [CW-1:0]      free_head_r, free_head_nxt;
  logic [CW:0]        free_count_r, free_count_nxt;
  logic [GW-1:0]      order_head_r, order_head_nxt, order_tail_r, order_tail_nxt;
  logic [GW:0]        order_count_r, order_count_nxt;
  logic [FIELD_W-1:0] elem_r, elem_nxt;
  logic               elem_ok_r, elem_ok_nxt;
  logic [GW-1:0]      g_r, g_nxt;
  logic [CW-1:0]      e_r, e_nxt, nf_r, nf_nxt, t_r, t_nxt;
  logic [FIELD_W-1:0] res_elem_r, res_elem_nxt;
  status_t            res_st_r, res_st_nxt;
  logic               clr_pend_r, clr_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_elem_r, out_elem_nxt;
  status_t            out_st_r, out_st_nxt;

  logic [31:0]        clr_w;
  logic [GW-1:0]      g_enq;

  assign clr_w       = 32'(clr_r);
  assign g_enq       = elem_ok_r ? eg_q : '0;
  assign clearing    = state_r == S_CLR;
  assign out_valid   = out_valid_r;
  assign out_element = out_elem_r;
  assign out_status  = out_st_r;

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (eg_we) eg_mem[eg_wa] <= eg_wd;
    eg_q <= eg_mem[eg_ra];
  end
  always_ff @(posedge clk) begin
    if (gh_we) gh_mem[gh_wa] <= gh_wd;
    gh_q <= gh_mem[gh_ra];
  end
  always_ff @(posedge clk) begin
    if (gt_we) gt_mem[gt_wa] <= gt_wd;
    gt_q <= gt_mem[gt_ra];
  end
  always_ff @(posedge clk) begin
    if (gne_we) gne_mem[gne_wa] <= gne_wd;
    gne_q <= gne_mem[gne_ra];
  end
  always_ff @(posedge clk) begin
    if (ev_we) ev_mem[ev_wa] <= ev_wd;
    ev_q <= ev_mem[ev_ra];
  end
  always_ff @(posedge clk) begin
    if (en_we) en_mem[en_wa] <= en_wd;
    en_q <= en_mem[en_ra];
  end
  always_ff @(posedge clk) begin
    if (oq_we) oq_mem[oq_wa] <= oq_wd;
    oq_q <= oq_mem[oq_ra];
  end

  // Sequence each command through its reads and write-backs
  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    free_head_nxt   = free_head_r;
    free_count_nxt  = free_count_r;
    order_head_nxt  = order_head_r;
    order_tail_nxt  = order_tail_r;
    order_count_nxt = order_count_r;
    elem_nxt        = elem_r;
    elem_ok_nxt     = elem_ok_r;
    g_nxt           = g_r;
    e_nxt           = e_r;
    nf_nxt          = nf_r;
    t_nxt           = t_r;
    res_elem_nxt    = res_elem_r;
    res_st_nxt      = res_st_r;
    clr_pend_nxt    = clr_pend_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_elem_nxt    = out_elem_r;
    out_st_nxt      = out_st_r;
    cmd_pop         = 1'b0;
    eg_we = 1'b0; gh_we = 1'b0; gt_we = 1'b0; gne_we = 1'b0;
    ev_we = 1'b0; en_we = 1'b0; oq_we = 1'b0;
    eg_wa = '0; eg_wd = '0; eg_ra = EW'(cmd.elem);
    gh_wa = '0; gh_wd = '0; gh_ra = g_r;
    gt_wa = '0; gt_wd = '0; gt_ra = g_r;
    gne_wa = '0; gne_wd = 1'b0; gne_ra = g_r;
    ev_wa = '0; ev_wd = '0; ev_ra = e_r;
    en_wa = '0; en_wd = '0; en_ra = free_head_r;
    oq_wa = '0; oq_wd = '0; oq_ra = order_head_r;

    case (state_r)
      S_CLR: begin
        // Sweep: clear the group table and flags, rebuild the free chain
        eg_we  = clr_w < ELEMENTS;
        eg_wa  = EW'(clr_r);
        gne_we = clr_w < GROUPS;
        gne_wa = GW'(clr_r);
        en_we  = clr_w < CAPACITY;
        en_wa  = CW'(clr_r);
        en_wd  = (clr_w + 32'd1 >= CAPACITY) ? '0 : CW'(clr_w + 32'd1);
        if (clr_w == MAXD - 1) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + MW'(1);
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop      = 1'b1;
          res_elem_nxt = '0;
          res_st_nxt   = ST_ACCEPTED;
          state_nxt    = S_DONE;
          case (cmd.op)
            OP_ASSIGN: begin
              eg_we = cmd.elem_ok && cmd.grp_ok;
              eg_wa = EW'(cmd.elem);
              eg_wd = GW'(cmd.grp);
            end
            OP_ENQUEUE: begin
              if (free_count_r == '0) begin
                res_st_nxt = ST_FULL;
              end else begin
                elem_nxt    = cmd.elem;
                elem_ok_nxt = cmd.elem_ok;
                state_nxt   = S_E1;
              end
            end
            OP_DEQUEUE: begin
              if (order_count_r == '0) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_D1;
              end
            end
            default: begin
              free_head_nxt   = '0;
              free_count_nxt  = (CW+1)'(CAPACITY);
              order_head_nxt  = '0;
              order_tail_nxt  = '0;
              order_count_nxt = '0;
              clr_pend_nxt    = 1'b1;
            end
          endcase
        end
      end
      S_E1: begin
        // Group of the element and next free entry are back
        g_nxt     = g_enq;
        e_nxt     = free_head_r;
        nf_nxt    = en_q;
        gne_ra    = g_enq;
        gt_ra     = g_enq;
        state_nxt = S_E2;
      end
      S_E2: begin
        free_head_nxt  = nf_r;
        free_count_nxt = free_count_r - (CW+1)'(1);
        ev_we = 1'b1; ev_wa = e_r; ev_wd = elem_r;
        en_we = 1'b1; en_wa = e_r; en_wd = '0;
        gt_we = 1'b1; gt_wa = g_r; gt_wd = e_r;
        if (!gne_q) begin
          gne_we = 1'b1; gne_wa = g_r; gne_wd = 1'b1;
          gh_we  = 1'b1; gh_wa  = g_r; gh_wd  = e_r;
          oq_we  = 1'b1; oq_wa  = order_tail_r; oq_wd = g_r;
          order_tail_nxt  = (32'(order_tail_r) + 32'd1 >= GROUPS) ?
                            '0 : order_tail_r + GW'(1);
          order_count_nxt = order_count_r + (GW+1)'(1);
          state_nxt       = S_DONE;
        end else begin
          t_nxt     = gt_q;
          state_nxt = S_E3;
        end
      end
      S_E3: begin
        // Link the new entry behind the old group tail
        en_we = 1'b1; en_wa = t_r; en_wd = e_r;
        state_nxt = S_DONE;
      end
      S_D1: begin
        g_nxt     = oq_q;
        gh_ra     = oq_q;
        gt_ra     = oq_q;
        state_nxt = S_D2;
      end
      S_D2: begin
        e_nxt     = gh_q;
        t_nxt     = gt_q;
        ev_ra     = gh_q;
        en_ra     = gh_q;
        state_nxt = S_D3;
      end
      S_D3: begin
        res_elem_nxt = ev_q;
        res_st_nxt   = ST_VALID;
        if (e_r == t_r) begin
          gne_we = 1'b1; gne_wa = g_r; gne_wd = 1'b0;
          order_head_nxt  = (32'(order_head_r) + 32'd1 >= GROUPS) ?
                            '0 : order_head_r + GW'(1);
          order_count_nxt = order_count_r - (GW+1)'(1);
        end else begin
          gh_we = 1'b1; gh_wa = g_r; gh_wd = en_q;
        end
        // Return the entry to the free list
        en_we = 1'b1; en_wa = e_r; en_wd = free_head_r;
        free_head_nxt  = e_r;
        free_count_nxt = free_count_r + (CW+1)'(1);
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // Hand the word to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_elem_nxt  = res_elem_r;
          out_st_nxt    = res_st_r;
          clr_pend_nxt  = 1'b0;
          clr_nxt       = '0;
          state_nxt     = clr_pend_r ? S_CLR : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_r         <= '0;
      free_head_r   <= '0;
      free_count_r  <= (CW+1)'(CAPACITY);
      order_head_r  <= '0;
      order_tail_r  <= '0;
      order_count_r <= '0;
      clr_pend_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      free_head_r   <= free_head_nxt;
      free_count_r  <= free_count_nxt;
      order_head_r  <= order_head_nxt;
      order_tail_r  <= order_tail_nxt;
      order_count_r <= order_count_nxt;
      clr_pend_r    <= clr_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    elem_r     <= elem_nxt;
    elem_ok_r  <= elem_ok_nxt;
    g_r        <= g_nxt;
    e_r        <= e_nxt;
    nf_r       <= nf_nxt;
    t_r        <= t_nxt;
    res_elem_r <= res_elem_nxt;
    res_st_r   <= res_st_nxt;
    out_elem_r <= out_elem_nxt;
    out_st_r   <= out_st_nxt;
  end

endmodule

// ===== rtl/grouped_fifo_queue.sv =====
// Grouped FIFO queue: elements wait behind the last waiting member of their group.
// Assign, clear, full and empty words go from idle to done; enqueue passes E1,
// E2 and, if its group already waits, E3; dequeue passes D1, D2 and D3, set by
// the chain of registered reads through the pointer memories. The engine runs
// one word at a time, taking a new one only after the last leaves done; a two-word
// front buffer takes new words meanwhile. After reset and each clear a sweep of
// max(GROUPS, CAPACITY, ELEMENTS) addresses rebuilds the tables; no word runs then.
module grouped_fifo_queue #(
  parameter int GROUPS   = 1024,
  parameter int CAPACITY = 1024,
  parameter int ELEMENTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_operation,
  input  logic [gfq_pkg::FIELD_W-1:0] in_element,
  input  logic [gfq_pkg::FIELD_W-1:0] in_group,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [gfq_pkg::FIELD_W-1:0] out_element,
  output logic [1:0]            out_status
);
  import gfq_pkg::*;

  logic cmd_valid, cmd_pop, clearing;
  cmd_t cmd;

  gfq_front #(.GROUPS(GROUPS), .ELEMENTS(ELEMENTS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_element, .in_group,
    .cmd_valid, .cmd_pop, .cmd
  );

  gfq_back #(.GROUPS(GROUPS), .CAPACITY(CAPACITY), .ELEMENTS(ELEMENTS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_pop, .cmd, .clearing,
    .out_valid, .out_ready, .out_element, .out_status
  );

  // Engine only takes words that the front buffer holds
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid) else $error("pop from empty front buffer");

  // No word is executed during the clearing sweep
  a_clr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !cmd_pop) else $error("word taken during sweep");

  // Only a valid dequeue carries a nonzero element
  a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_VALID) |-> out_element == '0)
    else $error("element on a non-dequeue word");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the grouped FIFO queue: team order, free list and clear.
module tb_top;
  import gfq_pkg::*;

  localparam int NGRP = 1024;
  localparam int NCAP = 1024;
  localparam int NELM = 1024;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = OP_ASSIGN;
  logic [FIELD_W-1:0] in_element = '0;
  logic [FIELD_W-1:0] in_group = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [FIELD_W-1:0] out_element;
  logic [1:0] out_status;

  int err_count = 0;
  int cycles = 0;
  bit stim_done = 1'b0;

  // Report one mismatch and count it
  task automatic report(input string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    err_count++;
  endtask

  typedef struct {
    logic [FIELD_W-1:0] elem;
    status_t st;
  } result_t;

  // Team queue predictor and store of expected results
  class team_queue_board;
    int elem_team[NELM];
    int team_members[NGRP][$];
    int team_order[$];
    int used;
    result_t pending[$];

    function void wipe();
      foreach (elem_team[i]) elem_team[i] = 0;
      foreach (team_members[i]) team_members[i].delete();
      team_order.delete();
      used = 0;
    endfunction

    // Apply one accepted word and note its expected result
    function void note_word(op_t op, int elem, int grp);
      result_t r;
      int g;
      r.elem = '0;
      r.st = ST_ACCEPTED;
      case (op)
        OP_ASSIGN: begin
          if (elem < NELM && grp < NGRP) elem_team[elem] = grp;
        end
        OP_ENQUEUE: begin
          if (used == NCAP) begin
            r.st = ST_FULL;
          end else begin
            g = (elem < NELM) ? elem_team[elem] : 0;
            if (team_members[g].size() == 0) team_order.push_back(g);
            team_members[g].push_back(elem);
            used++;
          end
        end
        OP_DEQUEUE: begin
          if (team_order.size() == 0) begin
            r.st = ST_EMPTY;
          end else begin
            g = team_order[0];
            r.elem = FIELD_W'(team_members[g].pop_front());
            r.st = ST_VALID;
            if (team_members[g].size() == 0) void'(team_order.pop_front());
            used--;
          end
        end
        default: wipe();
      endcase
      pending.push_back(r);
    endfunction

    // Compare one received result with the oldest expectation
    task check_result(logic [FIELD_W-1:0] elem, logic [1:0] st);
      result_t r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word elem=%0d status=%0d", elem, st));
      end else begin
        r = pending.pop_front();
        if (st !== r.st)
          report($sformatf("status %0d, want %0d", st, r.st));
        if (elem !== r.elem)
          report($sformatf("element %0d, want %0d", elem, r.elem));
      end
    endtask
  endclass

  team_queue_board board = new();

  grouped_fifo_queue i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_element(in_element), .in_group(in_group),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_element(out_element), .out_status(out_status)
  );

  always #5 clk = ~clk;

  // Count cycles and stop on the limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sample results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_element, out_status);
  end

  // Stall the receiver on its own pattern
  int stall_mode = 0;
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycles % 7) < 4;
    endcase
  end

  int burst_left = 0;

  // Send one word, with bursts and gaps before it
  task automatic send_word(input op_t op, input int elem, input int grp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_operation <= op;
    in_element <= FIELD_W'(elem);
    in_group <= FIELD_W'(grp);
    do @(posedge clk); while (!in_ready);
    board.note_word(op, elem, grp);
    @(negedge clk);
  endtask

  int n_items;
  int op_pick;
  int pool_base;

  initial begin
    board.wipe();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty, extremes, team order, clear
    send_word(OP_DEQUEUE, 0, 0);
    send_word(OP_ASSIGN, 1023, 1023);
    send_word(OP_ASSIGN, 0, 682);
    send_word(OP_ASSIGN, 341, 341);
    send_word(OP_ENQUEUE, 5, 0);
    send_word(OP_ENQUEUE, 1023, 0);
    send_word(OP_ENQUEUE, 341, 1023);
    send_word(OP_ENQUEUE, 7, 0);
    send_word(OP_ENQUEUE, 0, 0);
    send_word(OP_ENQUEUE, 1023, 0);
    send_word(OP_DEQUEUE, 0, 0);
    send_word(OP_DEQUEUE, 1023, 1023);
    send_word(OP_DEQUEUE, 0, 0);
    send_word(OP_DEQUEUE, 0, 0);
    send_word(OP_DEQUEUE, 0, 0);
    send_word(OP_DEQUEUE, 0, 0);
    send_word(OP_DEQUEUE, 0, 0);
    send_word(OP_ENQUEUE, 9, 0);
    send_word(OP_CLEAR, 1023, 1023);
    send_word(OP_ENQUEUE, 1023, 0);
    send_word(OP_DEQUEUE, 0, 0);

    // Random: scenarios of an optional clear, assigns, then mixed enqueue/dequeue/assign over a small pool
    n_items = 0;
    while (n_items < 600) begin
      if ($urandom_range(0, 2) == 0) begin
        send_word(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023));
        n_items++;
      end
      pool_base = $urandom_range(0, 1000);
      repeat ($urandom_range(2, 10)) begin
        send_word(OP_ASSIGN, pool_base + $urandom_range(0, 23),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, 5));
        n_items++;
      end
      repeat ($urandom_range(10, 40)) begin
        op_pick = $urandom_range(0, 9);
        if (op_pick < 5)
          send_word(OP_ENQUEUE, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                : pool_base + $urandom_range(0, 23), $urandom_range(0, 1023));
        else if (op_pick < 9)
          send_word(OP_DEQUEUE, $urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          send_word(OP_ASSIGN, $urandom_range(0, 1023), $urandom_range(0, 1023));
        n_items++;
      end
    end
    in_valid <= 1'b0;

    // Drain expectations, then settle
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
